// File: design/lambertian_pixel_shader_macros.svh
// assertion macros used by the shader top level
`ifndef LAMBERTIAN_PIXEL_SHADER_MACROS_SVH
`define LAMBERTIAN_PIXEL_SHADER_MACROS_SVH

// same-cycle implication, checked outside reset
`define LPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define LPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: design/lps_pkg.sv
// shared constants and stage hand-off types for the lambertian pixel shader
package lps_pkg;

  localparam logic [1:0] CFG_LIGHT_X = 2'd0;
  localparam logic [1:0] CFG_LIGHT_Y = 2'd1;
  localparam logic [1:0] CFG_LIGHT_Z = 2'd2;

  localparam logic [7:0] AMBIENT_LEVEL = 8'd51;
  localparam logic [7:0] DIFFUSE_SPAN  = 8'd204;

  localparam int S_W  = 66;   // sum of squared light vector components
  localparam int Q_W  = 57;   // 204 * dot product, positive case
  localparam int Q2_W = 114;  // q squared
  localparam int A_W  = 82;   // k^2 * s
  localparam int B_W  = 74;   // k * s

  localparam int SEARCH_STAGES = 8;  // one bit of the 8-bit level per stage

  typedef struct packed {
    logic             pos;
    logic [S_W-1:0]   s;
    logic [Q_W-1:0]   q;
  } front_t;

  typedef struct packed {
    logic             pos;
    logic [S_W-1:0]   s;
    logic [Q2_W-1:0]  q2;
  } qsq_t;

  typedef struct packed {
    logic        pos;
    logic [7:0]  k;
  } level_t;

endpackage

// File: design/lps_front.sv
// light vector, products, sums and scaled dot product (four stages)
module lps_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [31:0]    light_x,
  input  logic signed [31:0]    light_y,
  input  logic signed [31:0]    light_z,
  input  logic signed [31:0]    point_x,
  input  logic signed [31:0]    point_y,
  input  logic signed [31:0]    point_z,
  input  logic signed [15:0]    normal_x,
  input  logic signed [15:0]    normal_y,
  input  logic signed [15:0]    normal_z,
  output logic                  dn_valid,
  output lps_pkg::front_t       dn_data,
  input  logic                  dn_ready
);

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  logic signed [32:0] dx, dy, dz;
  logic signed [15:0] nx, ny, nz;
  logic [63:0]        sqx, sqy, sqz;
  logic signed [48:0] prx, pry, prz;
  logic [lps_pkg::S_W-1:0] s3, s4;
  logic signed [49:0] p3;
  logic               pos4;
  logic [lps_pkg::Q_W-1:0] q4;

  logic signed [65:0] sqx_full, sqy_full, sqz_full;
  logic signed [48:0] prx_full, pry_full, prz_full;
  logic [lps_pkg::Q_W-1:0] q_full;
  logic               p_pos;

  assign rdy4 = !v4 || dn_ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign in_ready = rdy1;

  assign sqx_full = dx * dx;
  assign sqy_full = dy * dy;
  assign sqz_full = dz * dz;
  assign prx_full = dx * nx;
  assign pry_full = dy * ny;
  assign prz_full = dz * nz;

  assign p_pos  = !p3[49] && (|p3);
  assign q_full = {8'd0, p3[48:0]} * lps_pkg::Q_W'(lps_pkg::DIFFUSE_SPAN);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      dx <= {light_x[31], light_x} - {point_x[31], point_x};
      dy <= {light_y[31], light_y} - {point_y[31], point_y};
      dz <= {light_z[31], light_z} - {point_z[31], point_z};
      nx <= normal_x;
      ny <= normal_y;
      nz <= normal_z;
    end
    if (rdy2) begin
      sqx <= sqx_full[63:0];
      sqy <= sqy_full[63:0];
      sqz <= sqz_full[63:0];
      prx <= prx_full;
      pry <= pry_full;
      prz <= prz_full;
    end
    if (rdy3) begin
      s3 <= {2'b00, sqx} + {2'b00, sqy} + {2'b00, sqz};
      p3 <= {prx[48], prx} + {pry[48], pry} + {prz[48], prz};
    end
    if (rdy4) begin
      s4   <= s3;
      pos4 <= p_pos;
      q4   <= p_pos ? q_full : '0;
    end
  end

  assign dn_valid   = v4;
  assign dn_data.pos = pos4;
  assign dn_data.s   = s4;
  assign dn_data.q   = q4;

endmodule

// File: design/lps_qsq.sv
// squares the scaled dot product through partial products (two stages)
module lps_qsq (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  lps_pkg::front_t   up_data,
  output logic              dn_valid,
  output lps_pkg::qsq_t     dn_data,
  input  logic              dn_ready
);

  logic v1, v2, rdy1, rdy2;
  logic [27:0] qh;
  logic [28:0] ql;
  logic [55:0] hh;
  logic [56:0] hl;
  logic [57:0] ll;
  logic        pos1, pos2;
  logic [lps_pkg::S_W-1:0]  s1, s2;
  logic [lps_pkg::Q2_W-1:0] q2;

  assign rdy2 = !v2 || dn_ready;
  assign rdy1 = !v1 || rdy2;
  assign up_ready = rdy1;

  assign qh = up_data.q[56:29];
  assign ql = up_data.q[28:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (rdy1) v1 <= up_valid;
      if (rdy2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) begin
      hh   <= {28'd0, qh} * {28'd0, qh};
      hl   <= {29'd0, qh} * {28'd0, ql};
      ll   <= {29'd0, ql} * {29'd0, ql};
      pos1 <= up_data.pos;
      s1   <= up_data.s;
    end
    if (rdy2) begin
      q2   <= (lps_pkg::Q2_W'(hh) << 58) + (lps_pkg::Q2_W'(hl) << 30)
              + lps_pkg::Q2_W'(ll);
      pos2 <= pos1;
      s2   <= s1;
    end
  end

  assign dn_valid    = v2;
  assign dn_data.pos = pos2;
  assign dn_data.s   = s2;
  assign dn_data.q2  = q2;

endmodule

// File: design/lps_search.sv
// bit-per-stage search for the largest k with k^2 * 2^28 * s <= q^2
module lps_search (
  input  logic              clk,
  input  logic              rst,
  input  logic              up_valid,
  output logic              up_ready,
  input  lps_pkg::qsq_t     up_data,
  output logic              dn_valid,
  output lps_pkg::level_t   dn_data,
  input  logic              dn_ready
);

  logic                     v   [lps_pkg::SEARCH_STAGES];
  logic                     rdy [lps_pkg::SEARCH_STAGES];
  logic [7:0]               k   [lps_pkg::SEARCH_STAGES];
  logic [lps_pkg::A_W-1:0]  a   [lps_pkg::SEARCH_STAGES];
  logic [lps_pkg::B_W-1:0]  b   [lps_pkg::SEARCH_STAGES];
  logic [lps_pkg::S_W-1:0]  s   [lps_pkg::SEARCH_STAGES];
  logic [lps_pkg::Q2_W-1:0] q2  [lps_pkg::SEARCH_STAGES];
  logic                     pos [lps_pkg::SEARCH_STAGES];

  for (genvar g = 0; g < lps_pkg::SEARCH_STAGES; g++) begin : g_stage
    localparam int J = lps_pkg::SEARCH_STAGES - 1 - g;

    logic                     src_v;
    logic [7:0]               src_k;
    logic [lps_pkg::A_W-1:0]  src_a, a_try;
    logic [lps_pkg::B_W-1:0]  src_b;
    logic [lps_pkg::S_W-1:0]  src_s;
    logic [lps_pkg::Q2_W-1:0] src_q2;
    logic                     src_pos;
    logic                     down_rdy;
    logic                     fit;

    if (g == 0) begin : g_head
      assign src_v   = up_valid;
      assign src_k   = '0;
      assign src_a   = '0;
      assign src_b   = '0;
      assign src_s   = up_data.s;
      assign src_q2  = up_data.q2;
      assign src_pos = up_data.pos;
    end else begin : g_body
      assign src_v   = v[g-1];
      assign src_k   = k[g-1];
      assign src_a   = a[g-1];
      assign src_b   = b[g-1];
      assign src_s   = s[g-1];
      assign src_q2  = q2[g-1];
      assign src_pos = pos[g-1];
    end

    if (g == lps_pkg::SEARCH_STAGES - 1) begin : g_tail
      assign down_rdy = dn_ready;
    end else begin : g_mid
      assign down_rdy = rdy[g+1];
    end

    assign rdy[g] = !v[g] || down_rdy;

    // (k + 2^J)^2 s = k^2 s + 2^(J+1) k s + 2^(2J) s
    assign a_try = src_a + (lps_pkg::A_W'(src_b) << (J + 1))
                   + (lps_pkg::A_W'(src_s) << (2 * J));
    assign fit   = {4'd0, a_try, 28'd0} <= src_q2;

    always_ff @(posedge clk) begin
      if (rst) begin
        v[g] <= 1'b0;
      end else if (rdy[g]) begin
        v[g] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[g]) begin
        s[g]   <= src_s;
        q2[g]  <= src_q2;
        pos[g] <= src_pos;
        if (fit) begin
          k[g] <= src_k | (8'd1 << J);
          a[g] <= a_try;
          b[g] <= src_b + (lps_pkg::B_W'(src_s) << J);
        end else begin
          k[g] <= src_k;
          a[g] <= src_a;
          b[g] <= src_b;
        end
      end
    end
  end

  assign up_ready    = rdy[0];
  assign dn_valid    = v[lps_pkg::SEARCH_STAGES-1];
  assign dn_data.pos = pos[lps_pkg::SEARCH_STAGES-1];
  assign dn_data.k   = k[lps_pkg::SEARCH_STAGES-1];

endmodule

// File: design/lambertian_pixel_shader.sv
// top level of the lambertian pixel shader: config registers, pipeline, output register
//
// channel  | signals                                      | direction
// ---------+----------------------------------------------+----------
// cfg      | cfg_valid cfg_ready cfg_index cfg_data       | in
// in       | in_valid in_ready point_* normal_*           | in
// out      | out_valid out_ready grey                     | out
//
// one pixel per clock sustained while out_ready holds; from input transfer to result valid
// the data passes 4 front stages, 2 squaring stages, 8 search stages, 1 output register
// the level search takes 8 steps, one result bit per stage
// every stage holds its own valid bit; a stall only backs up full stages
// rst (synchronous) clears all valid bits and the light position to zero
module lambertian_pixel_shader (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic signed [31:0] point_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         grey
);

`include "lambertian_pixel_shader_macros.svh"

  logic signed [31:0] light_x, light_y, light_z;

  logic             fr_valid, fr_ready;
  lps_pkg::front_t  fr_data;
  logic             qs_valid, qs_ready;
  lps_pkg::qsq_t    qs_data;
  logic             lv_valid, lv_ready;
  lps_pkg::level_t  lv_data;
  logic [7:0]       grey_next;
  logic [7:0]       k_clamped;

  // config writes land at once, the port never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_x <= '0;
      light_y <= '0;
      light_z <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lps_pkg::CFG_LIGHT_X: light_x <= cfg_data;
        lps_pkg::CFG_LIGHT_Y: light_y <= cfg_data;
        lps_pkg::CFG_LIGHT_Z: light_z <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  lps_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .light_x  (light_x),
    .light_y  (light_y),
    .light_z  (light_z),
    .point_x  (point_x),
    .point_y  (point_y),
    .point_z  (point_z),
    .normal_x (normal_x),
    .normal_y (normal_y),
    .normal_z (normal_z),
    .dn_valid (fr_valid),
    .dn_data  (fr_data),
    .dn_ready (fr_ready)
  );

  lps_qsq u_qsq (
    .clk      (clk),
    .rst      (rst),
    .up_valid (fr_valid),
    .up_ready (fr_ready),
    .up_data  (fr_data),
    .dn_valid (qs_valid),
    .dn_data  (qs_data),
    .dn_ready (qs_ready)
  );

  lps_search u_search (
    .clk      (clk),
    .rst      (rst),
    .up_valid (qs_valid),
    .up_ready (qs_ready),
    .up_data  (qs_data),
    .dn_valid (lv_valid),
    .dn_data  (lv_data),
    .dn_ready (lv_ready)
  );

  // output register takes a new result whenever it is empty or being drained
  assign lv_ready = !out_valid || out_ready;

  // non-unit normals can push k past the span, saturate there
  assign k_clamped = (lv_data.k > lps_pkg::DIFFUSE_SPAN) ? lps_pkg::DIFFUSE_SPAN : lv_data.k;
  // facing away or zero-length light vector leaves only the ambient term
  assign grey_next = lv_data.pos ? (lps_pkg::AMBIENT_LEVEL + k_clamped)
                                 : lps_pkg::AMBIENT_LEVEL;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (lv_ready) begin
      out_valid <= lv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (lv_ready) begin
      grey <= grey_next;
    end
  end

  `LPS_ASSERT_NOW(a_grey_floor, out_valid, grey >= lps_pkg::AMBIENT_LEVEL, "grey below ambient")
  `LPS_ASSERT_NOW(a_stall_source, !in_ready, out_valid && !out_ready, "input stalled without output backpressure")
  `LPS_ASSERT_NOW(a_light_reset, $past(rst), light_x == 0 && light_y == 0 && light_z == 0, "light not cleared by reset")

endmodule
